/* hdl/ccr_pkg.sv */
// shared constants and helper functions for the clock calendar register file
package ccr_pkg;

    // access kinds
    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // register numbers
    localparam logic [3:0] REG_SECONDS  = 4'd8;
    localparam logic [3:0] REG_MINUTES  = 4'd9;
    localparam logic [3:0] REG_HOURS    = 4'd10;
    localparam logic [3:0] REG_DAY_LOW  = 4'd11;
    localparam logic [3:0] REG_DAY_HIGH = 4'd12;

    // field weights in seconds
    localparam logic [31:0] UNIT_SECOND   = 32'd1;
    localparam logic [31:0] UNIT_MINUTE   = 32'd60;
    localparam logic [31:0] UNIT_HOUR     = 32'd3600;
    localparam logic [31:0] UNIT_DAY      = 32'd86400;
    localparam logic [31:0] UNIT_256_DAYS = 32'd22118400;

    // reciprocals: x / 60 = (x * RECIP_60) >> 37, x / 3 = (x * RECIP_3) >> 33
    localparam logic [31:0] RECIP_60       = 32'h8888_8889;
    localparam int          RECIP_60_SHIFT = 37;
    localparam logic [31:0] RECIP_3        = 32'hAAAA_AAAB;
    localparam int          RECIP_3_SHIFT  = 33;

    // byte modulo 60 through a short reciprocal (q = d * 137 >> 13)
    function automatic logic [5:0] mod60_byte(input logic [7:0] d);
        logic [15:0] p;
        logic [8:0]  t;
        logic [7:0]  r;
        p = 16'(d) * 16'd137;
        t = 9'(p[15:13]) * 9'd60;
        r = d - t[7:0];
        return r[5:0];
    endfunction

    // byte modulo 24 through a short reciprocal (q = d * 171 >> 12)
    function automatic logic [4:0] mod24_byte(input logic [7:0] d);
        logic [15:0] p;
        logic [7:0]  t;
        logic [7:0]  r;
        p = 16'(d) * 16'd171;
        t = 8'(p[15:12]) * 8'd24;
        r = d - t;
        return r[4:0];
    endfunction

    // low six bits of q * 60
    function automatic logic [5:0] mul60_lo6(input logic [5:0] q);
        logic [11:0] t;
        t = {q, 6'b0} - {4'b0, q, 2'b0};
        return t[5:0];
    endfunction

    // low five bits of q * 24
    function automatic logic [4:0] mul24_lo5(input logic [4:0] q);
        logic [9:0] t;
        t = {1'b0, q, 4'b0} + {2'b0, q, 3'b0};
        return t[4:0];
    endfunction

endpackage

/* hdl/clock_calendar_registers_top.sv */
// clock calendar register file: offset register, field extraction pipeline, write update
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------------------
//  access  | in        | i_valid / o_stall  | i_action, i_reg_select, i_write_data,
//          |           |                    | i_now_seconds
//  result  | out       | o_valid / i_stall  | o_read_data
//
// items pass the input, elapsed, minutes, hours and day stages, then the output register
// reads flow one item per cycle while no write is in flight and i_stall is low;
// each stage has its own valid and holds only when full; a write keeps o_stall high until
// it retires; this is the offset loop through the divide-by-60/60/24 chain
// synchronous active-low reset clears the offset and all valid bits
// while o_valid waits under i_stall, empty stages behind it keep taking items
module clock_calendar_registers_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [3:0]  i_reg_select,
    input  logic [7:0]  i_write_data,
    input  logic [31:0] i_now_seconds,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_read_data
);
    import ccr_pkg::*;

    // offset state
    logic [31:0] r_offset;
    logic [31:0] n_offset;

    // stage 1: input register
    logic        r_v1, r_a1;
    logic [3:0]  r_sel1;
    logic [7:0]  r_d1;
    logic [31:0] r_now1;

    // stage 2: elapsed time
    logic        r_v2, r_a2;
    logic [3:0]  r_sel2;
    logic [7:0]  r_d2;
    logic [31:0] r_e2;

    // stage 3: minutes count
    logic        r_v3, r_a3;
    logic [3:0]  r_sel3;
    logic [7:0]  r_d3;
    logic [5:0]  r_elo3;
    logic [26:0] r_q1_3;

    // stage 4: hours count
    logic        r_v4, r_a4;
    logic [3:0]  r_sel4;
    logic [7:0]  r_d4;
    logic [5:0]  r_sec4;
    logic [5:0]  r_q1lo4;
    logic [20:0] r_q2_4;

    // stage 5: day count
    logic        r_v5, r_a5;
    logic [3:0]  r_sel5;
    logic [7:0]  r_d5;
    logic [5:0]  r_sec5;
    logic [5:0]  r_min5;
    logic [4:0]  r_q2lo5;
    logic [15:0] r_q3_5;

    // output register
    logic        r_ov;
    logic [7:0]  r_rd;

    // stage ready chain
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
    logic wr_busy, in_acc, wr_commit;

    assign rdy6 = !r_ov || !i_stall;
    assign rdy5 = !r_v5 || rdy6;
    assign rdy4 = !r_v4 || rdy5;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    // a write in flight holds new items off until the offset is updated
    assign wr_busy = (r_v1 && r_a1 == ACT_WRITE) || (r_v2 && r_a2 == ACT_WRITE)
                  || (r_v3 && r_a3 == ACT_WRITE) || (r_v4 && r_a4 == ACT_WRITE)
                  || (r_v5 && r_a5 == ACT_WRITE);
    assign o_stall   = !rdy1 || wr_busy;
    assign in_acc    = i_valid && !o_stall;
    assign wr_commit = r_v5 && r_a5 == ACT_WRITE && rdy6;

    // elapsed time
    logic [31:0] n_e;
    assign n_e = r_now1 - r_offset;

    // minutes count: e / 60
    logic [63:0] p1;
    logic [26:0] n_q1;
    assign p1   = 64'(r_e2) * 64'(RECIP_60);
    assign n_q1 = p1[63:RECIP_60_SHIFT];

    // seconds field and hours count: q1 / 60
    logic [5:0]  n_sec;
    logic [58:0] p2;
    logic [20:0] n_q2;
    assign n_sec = r_elo3 - mul60_lo6(r_q1_3[5:0]);
    assign p2    = 59'(r_q1_3) * 59'(RECIP_60);
    assign n_q2  = p2[57:RECIP_60_SHIFT];

    // minutes field and day count: q2 / 24 = (q2 / 8) / 3
    logic [5:0]  n_min;
    logic [49:0] p3;
    logic [15:0] n_q3;
    assign n_min = r_q1lo4 - mul60_lo6(r_q2_4[5:0]);
    assign p3    = 50'(r_q2_4[20:3]) * 50'(RECIP_3);
    assign n_q3  = p3[48:RECIP_3_SHIFT];

    // hours field, read selection and offset adjustment
    logic [4:0]        hr5;
    logic [7:0]        fld;
    logic [7:0]        old_v;
    logic [7:0]        new_v;
    logic [31:0]       unit;
    logic signed [8:0] diff;
    logic [31:0]       delta;
    logic [7:0]        n_rd;

    assign hr5 = r_q2lo5 - mul24_lo5(r_q3_5[4:0]);

    always_comb begin
        fld   = 8'd0;
        old_v = 8'd0;
        new_v = 8'd0;
        unit  = 32'd0;
        unique case (r_sel5)
            REG_SECONDS: begin
                fld   = {2'b0, r_sec5};
                old_v = {2'b0, r_sec5};
                new_v = {2'b0, mod60_byte(r_d5)};
                unit  = UNIT_SECOND;
            end
            REG_MINUTES: begin
                fld   = {2'b0, r_min5};
                old_v = {2'b0, r_min5};
                new_v = {2'b0, mod60_byte(r_d5)};
                unit  = UNIT_MINUTE;
            end
            REG_HOURS: begin
                fld   = {3'b0, hr5};
                old_v = {3'b0, hr5};
                new_v = {3'b0, mod24_byte(r_d5)};
                unit  = UNIT_HOUR;
            end
            REG_DAY_LOW: begin
                fld   = r_q3_5[7:0];
                old_v = r_q3_5[7:0];
                new_v = r_d5;
                unit  = UNIT_DAY;
            end
            REG_DAY_HIGH: begin
                fld   = {7'b0, r_q3_5[8]};
                old_v = r_q3_5[15:8];
                new_v = {7'b0, r_d5[0]};
                unit  = UNIT_256_DAYS;
            end
            default: begin
                fld   = 8'd0;
                old_v = 8'd0;
                new_v = 8'd0;
                unit  = 32'd0;
            end
        endcase
    end

    // new offset = offset - (new - old) * weight, modulo 2^32
    assign diff     = $signed({1'b0, old_v}) - $signed({1'b0, new_v});
    assign delta    = 32'({{23{diff[8]}}, diff} * unit);
    assign n_offset = r_offset + delta;
    assign n_rd     = (r_a5 == ACT_READ) ? fld : 8'd0;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= 32'd0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_v4     <= 1'b0;
            r_v5     <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (wr_commit) begin
                r_offset <= n_offset;
            end
            if (rdy1) begin
                r_v1 <= in_acc;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
            if (rdy5) begin
                r_v5 <= r_v4;
            end
            if (rdy6) begin
                r_ov <= r_v5;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (rdy1 && in_acc) begin
            r_a1   <= i_action;
            r_sel1 <= i_reg_select;
            r_d1   <= i_write_data;
            r_now1 <= i_now_seconds;
        end
        if (rdy2) begin
            r_a2   <= r_a1;
            r_sel2 <= r_sel1;
            r_d2   <= r_d1;
            r_e2   <= n_e;
        end
        if (rdy3) begin
            r_a3   <= r_a2;
            r_sel3 <= r_sel2;
            r_d3   <= r_d2;
            r_elo3 <= r_e2[5:0];
            r_q1_3 <= n_q1;
        end
        if (rdy4) begin
            r_a4    <= r_a3;
            r_sel4  <= r_sel3;
            r_d4    <= r_d3;
            r_sec4  <= n_sec;
            r_q1lo4 <= r_q1_3[5:0];
            r_q2_4  <= n_q2;
        end
        if (rdy5) begin
            r_a5    <= r_a4;
            r_sel5  <= r_sel4;
            r_d5    <= r_d4;
            r_sec5  <= r_sec4;
            r_min5  <= n_min;
            r_q2lo5 <= r_q2_4[4:0];
            r_q3_5  <= n_q3;
        end
        if (rdy6) begin
            r_rd <= n_rd;
        end
    end

    assign o_valid     = r_ov;
    assign o_read_data = r_rd;

    // a write reaching the last stage has no item behind it
    a_write_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && r_a5 == ACT_WRITE) |-> !(r_v1 || r_v2 || r_v3 || r_v4))
        else $error("item entered behind a pending write");

    // at most one write in flight
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({r_v1 && r_a1 == ACT_WRITE, r_v2 && r_a2 == ACT_WRITE,
                    r_v3 && r_a3 == ACT_WRITE, r_v4 && r_a4 == ACT_WRITE,
                    r_v5 && r_a5 == ACT_WRITE}) <= 1)
        else $error("two writes in flight");

    // offset only moves when a write retires
    a_offset_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !wr_commit |=> $stable(r_offset))
        else $error("offset changed without a write");

    // extracted fields stay in range
    a_field_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 |-> (r_sec5 < 6'd60 && r_min5 < 6'd60 && hr5 < 5'd24))
        else $error("time field out of range");

endmodule

/* test/clock_calendar_registers_tb.sv */
// testbench for the clock calendar register file: directed table, then random accesses
`timescale 1ns / 1ps

module testbench;
    import ccr_pkg::*;

    // register numbers that decode to nothing
    localparam logic [3:0] REG_NONE_LOW  = 4'd0;
    localparam logic [3:0] REG_NONE_MID  = 4'd13;
    localparam logic [3:0] REG_NONE_HIGH = 4'd15;
    localparam logic [31:0] NOW_MAX = 32'hFFFF_FFFF;
    localparam int ROWS = 27;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_action = ACT_READ;
    logic [3:0]  i_reg_select = REG_SECONDS;
    logic [7:0]  i_write_data = 8'd0;
    logic [31:0] i_now_seconds = 32'd0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_read_data;

    // one row of the directed plan; known rows carry a typed-in result
    typedef struct packed {
        logic        act;
        logic [3:0]  sel;
        logic [7:0]  data;
        logic [31:0] now;
        logic        known;
        logic [7:0]  want;
    } t_access_row;

    t_access_row plan [0:ROWS-1] = '{
        // reads after reset, offset zero
        '{ACT_READ,  REG_SECONDS,   8'd0,   32'd0,   1'b1, 8'd0},
        '{ACT_READ,  REG_SECONDS,   8'd0,   NOW_MAX, 1'b1, 8'd15},
        '{ACT_READ,  REG_MINUTES,   8'd0,   NOW_MAX, 1'b1, 8'd28},
        '{ACT_READ,  REG_HOURS,     8'd0,   NOW_MAX, 1'b1, 8'd6},
        '{ACT_READ,  REG_DAY_LOW,   8'd0,   NOW_MAX, 1'b1, 8'd46},
        '{ACT_READ,  REG_DAY_HIGH,  8'd0,   NOW_MAX, 1'b1, 8'd0},
        '{ACT_READ,  REG_NONE_LOW,  8'd0,   NOW_MAX, 1'b1, 8'd0},
        '{ACT_READ,  REG_NONE_HIGH, 8'd255, NOW_MAX, 1'b1, 8'd0},
        // write to an unknown register leaves the offset alone
        '{ACT_WRITE, REG_NONE_MID,  8'd255, 32'd12345, 1'b1, 8'd0},
        '{ACT_READ,  REG_SECONDS,   8'd0,   NOW_MAX, 1'b1, 8'd15},
        // field writes with out-of-range bytes
        '{ACT_WRITE, REG_SECONDS,   8'd255, 32'd1000, 1'b1, 8'd0},
        '{ACT_READ,  REG_SECONDS,   8'd0,   32'd1000, 1'b0, 8'd0},
        '{ACT_WRITE, REG_MINUTES,   8'd60,  32'd1000, 1'b1, 8'd0},
        '{ACT_READ,  REG_MINUTES,   8'd0,   32'd1000, 1'b0, 8'd0},
        '{ACT_WRITE, REG_MINUTES,   8'd255, 32'd5000, 1'b1, 8'd0},
        '{ACT_READ,  REG_MINUTES,   8'd0,   32'd5000, 1'b0, 8'd0},
        '{ACT_WRITE, REG_HOURS,     8'd24,  32'd5000, 1'b1, 8'd0},
        '{ACT_WRITE, REG_HOURS,     8'd255, 32'd9000, 1'b1, 8'd0},
        '{ACT_READ,  REG_HOURS,     8'd0,   32'd9000, 1'b0, 8'd0},
        // day low write that wraps past 2^32
        '{ACT_WRITE, REG_DAY_LOW,   8'd255, NOW_MAX,  1'b1, 8'd0},
        '{ACT_READ,  REG_DAY_LOW,   8'd0,   NOW_MAX,  1'b0, 8'd0},
        '{ACT_READ,  REG_SECONDS,   8'd0,   32'd0,    1'b0, 8'd0},
        // day high write drops the day count above bit 8
        '{ACT_WRITE, REG_DAY_HIGH,  8'd255, 32'd7,    1'b1, 8'd0},
        '{ACT_READ,  REG_DAY_HIGH,  8'd0,   32'd7,    1'b0, 8'd0},
        '{ACT_WRITE, REG_DAY_HIGH,  8'd254, 32'd7,    1'b1, 8'd0},
        '{ACT_READ,  REG_DAY_LOW,   8'd0,   32'd7,    1'b0, 8'd0},
        '{ACT_READ,  REG_DAY_HIGH,  8'd0,   32'd7,    1'b0, 8'd0}
    };

    logic [31:0] offset_model = 32'd0;
    logic [7:0]  expected_bytes [$];
    logic [7:0]  oldest_byte;
    logic [31:0] wall_clock = 32'd0;
    int          mismatches = 0;
    int          sender_idle_pct = 30;
    int          receiver_idle_pct = 45;

    clock_calendar_registers_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_reg_select  (i_reg_select),
        .i_write_data  (i_write_data),
        .i_now_seconds (i_now_seconds),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_read_data   (o_read_data)
    );

    always #5 i_clk = ~i_clk;

    // field of elapsed time that a read returns
    function automatic logic [7:0] clock_field(input logic [31:0] e, input logic [3:0] sel);
        case (sel)
            REG_SECONDS:  return 8'(e % UNIT_MINUTE);
            REG_MINUTES:  return 8'((e / UNIT_MINUTE) % 32'd60);
            REG_HOURS:    return 8'((e / UNIT_HOUR) % 32'd24);
            REG_DAY_LOW:  return 8'((e / UNIT_DAY) & 32'hFF);
            REG_DAY_HIGH: return 8'((e / UNIT_256_DAYS) & 32'd1);
            default:      return 8'd0;
        endcase
    endfunction

    // advances the offset model by one access and returns the byte it reads back
    function automatic logic [7:0] apply_access(input logic act, input logic [3:0] sel,
                                                input logic [7:0] data,
                                                input logic [31:0] now);
        logic [31:0] e;
        logic [31:0] d;
        e = now - offset_model;
        d = 32'(data);
        if (act == ACT_READ)
            return clock_field(e, sel);
        case (sel)
            REG_SECONDS:
                e = (e / UNIT_MINUTE) * UNIT_MINUTE + d % 32'd60;
            REG_MINUTES:
                e = (e / UNIT_HOUR) * UNIT_HOUR + (d % 32'd60) * UNIT_MINUTE
                    + e % UNIT_MINUTE;
            REG_HOURS:
                e = (e / UNIT_DAY) * UNIT_DAY + (d % 32'd24) * UNIT_HOUR + e % UNIT_HOUR;
            REG_DAY_LOW:
                e = (e / UNIT_256_DAYS) * UNIT_256_DAYS + d * UNIT_DAY + e % UNIT_DAY;
            REG_DAY_HIGH:
                e = (d & 32'd1) * UNIT_256_DAYS + e % UNIT_256_DAYS;
            default: ;
        endcase
        offset_model = now - e;
        return 8'd0;
    endfunction

    // present one item after a random gap and hold it until taken
    task automatic send_access(input logic act, input logic [3:0] sel,
                               input logic [7:0] data, input logic [31:0] now,
                               input logic known, input logic [7:0] want);
        int gap;
        logic [7:0] predicted;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct && gap < 40)
            gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_action      <= act;
        i_reg_select  <= sel;
        i_write_data  <= data;
        i_now_seconds <= now;
        do @(posedge i_clk); while (o_stall);
        predicted = apply_access(act, sel, data, now);
        expected_bytes.push_back(known ? want : predicted);
    endtask

    // random access: mostly known registers against a clock that mostly moves forward
    task automatic send_random_access();
        logic       act;
        logic [3:0] sel;
        int         pick;
        act = ($urandom_range(99) < 40) ? ACT_WRITE : ACT_READ;
        sel = ($urandom_range(99) < 85) ? 4'($urandom_range(REG_SECONDS, REG_DAY_HIGH))
                                        : 4'($urandom_range(15));
        pick = $urandom_range(99);
        if (pick < 15)
            wall_clock = $urandom();
        else if (pick < 20)
            wall_clock = ($urandom_range(1) != 0) ? NOW_MAX : 32'd0;
        else if (pick < 30)
            wall_clock = wall_clock + $urandom_range(200000);
        else
            wall_clock = wall_clock + $urandom_range(90);
        send_access(act, sel, 8'($urandom_range(255)), wall_clock, 1'b0, 8'd0);
    endtask

    // result side: compare with the oldest expectation, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected item, expected none, got read_data %0d",
                         $time, o_read_data);
                mismatches++;
            end else begin
                oldest_byte = expected_bytes.pop_front();
                if (o_read_data !== oldest_byte) begin
                    $display("%0t: read_data expected %0d, got %0d",
                             $time, oldest_byte, o_read_data);
                    mismatches++;
                end
            end
        end
        i_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    // main sequence
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int r = 0; r < ROWS; r++)
            send_access(plan[r].act, plan[r].sel, plan[r].data, plan[r].now,
                        plan[r].known, plan[r].want);
        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct   = (phase == 0) ? 30 : (phase == 1) ? 45 : 0;
            receiver_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 30 : 0;
            repeat (350) send_random_access();
        end
        i_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

/* clock_calendar_registers_top.f */
hdl/ccr_pkg.sv
hdl/clock_calendar_registers_top.sv
test/clock_calendar_registers_tb.sv
